// ----- sv/jacobian_frame_completion_top_assert.svh -----
// Assertion macros for the Jacobian frame completion block.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef JACOBIAN_FRAME_COMPLETION_TOP_ASSERT_SVH
`define JACOBIAN_FRAME_COMPLETION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset
`define JFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jfc: implication check failed");
// Next-cycle implication, checked on every rising edge out of reset
`define JFC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jfc: next-cycle check failed");
`else
`define JFC_ASSERT_IMP(label, ante, cons)
`define JFC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- sv/jfc_pkg.sv -----
// Shared types and constants for the Jacobian frame completion block.
// No dependencies; imported by every module of the block.
`default_nettype none
package jfc_pkg;

    localparam int WORD_W = 32;
    localparam int ROOT_W = 32;
    localparam int WIDE_W = 64;

    // configuration register indexes
    localparam logic REG_AMBIENT   = 1'b0;
    localparam logic REG_REFERENCE = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;

    // completion case, decided when a request enters
    typedef enum logic [2:0] {
        MODE_PASS   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NORM2  = 3'd2,
        MODE_HH3    = 3'd3,
        MODE_CROSS3 = 3'd4
    } mode_t;

    // per-request data that travels beside the arithmetic
    typedef struct packed {
        mode_t                   mode;
        logic [1:0]              amb;
        logic [2:0]              cnt;
        logic [2:0]              neg;
        logic                    degen;
        logic [5:0][WORD_W-1:0]  a;
    } side_t;

endpackage
`default_nettype wire

// ----- sv/jfc_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// Uses jfc_pkg; instantiated by jacobian_frame_completion_top.
`default_nettype none
module jfc_div_pipe #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 8,
    parameter int LANES  = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]                den,
    input  logic [SIDE_W-1:0]               side_in,
    output logic                            out_valid,
    output logic [LANES-1:0][QUO_W-1:0]     quo,
    output logic [SIDE_W-1:0]               side_out
);
    import jfc_pkg::*;

    logic [QUO_W-1:0]                       valid_reg;
    logic [QUO_W-1:0][LANES-1:0][QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0][SIDE_W-1:0]           side_reg;
    logic [QUO_W-2:0][LANES-1:0][NUM_W-1:0] rem_reg;
    logic [QUO_W-2:0][DEN_W-1:0]            den_reg;

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int BIT = QUO_W - 1 - s;
        logic                        valid_in;
        logic [LANES-1:0][NUM_W-1:0] rem_in;
        logic [LANES-1:0][QUO_W-1:0] quo_in;
        logic [DEN_W-1:0]            den_in;
        logic [SIDE_W-1:0]           side_s;
        logic [NUM_W-1:0]            trial;
        logic [LANES-1:0][NUM_W-1:0] rem_next;
        logic [LANES-1:0][QUO_W-1:0] quo_next;

        if (s == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = num;
            assign quo_in   = '0;
            assign den_in   = den;
            assign side_s   = side_in;
        end else begin : g_next
            assign valid_in = valid_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign quo_in   = quo_reg[s-1];
            assign den_in   = den_reg[s-1];
            assign side_s   = side_reg[s-1];
        end

        // subtract the shifted divisor where it fits
        assign trial = NUM_W'(den_in) << BIT;
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_next[l] = rem_in[l];
                quo_next[l] = quo_in[l];
                if (rem_in[l] >= trial)
                begin
                    rem_next[l]      = rem_in[l] - trial;
                    quo_next[l][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            quo_reg[s]  <= quo_next;
            side_reg[s] <= side_s;
        end

        if (s < QUO_W - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule
`default_nettype wire

// ----- sv/jacobian_frame_completion_top.sv -----
// Top level of the Jacobian frame completion block: config port and pipeline.
// Depends on jfc_pkg, jfc_div_pipe and jacobian_frame_completion_top_assert.svh.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------
//  request   | start, busy             | in0 .. in5 (Q.FRAC_BITS, signed)
//  result    | done (one-cycle strobe) | m0 .. m8, degenerate
//  config    | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// One request enters per cycle; busy stays low. On its way out a result
// passes 32 square-root stages and two dividers of FRAC_BITS+1 stages.
// Reset clears valid bits and restores ambient_dim = 3, reference_dim = 2.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module jacobian_frame_completion_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  logic            start,
    output logic            busy,
    input  jfc_pkg::word_t  in0,
    input  jfc_pkg::word_t  in1,
    input  jfc_pkg::word_t  in2,
    input  jfc_pkg::word_t  in3,
    input  jfc_pkg::word_t  in4,
    input  jfc_pkg::word_t  in5,
    output logic            done,
    output jfc_pkg::word_t  m0,
    output jfc_pkg::word_t  m1,
    output jfc_pkg::word_t  m2,
    output jfc_pkg::word_t  m3,
    output jfc_pkg::word_t  m4,
    output jfc_pkg::word_t  m5,
    output jfc_pkg::word_t  m6,
    output jfc_pkg::word_t  m7,
    output jfc_pkg::word_t  m8,
    output logic            degenerate
);
    import jfc_pkg::*;

    localparam int UW   = FRAC_BITS + 1;        // unit magnitude
    localparam int SW   = FRAC_BITS + 2;        // signed unit
    localparam int PW   = 2 * FRAC_BITS + 4;    // product of two signed units
    localparam int NW2  = 2 * FRAC_BITS + 3;    // second divider numerator
    localparam int SIDE_W = $bits(side_t);
    localparam int SIDE2_W = SIDE_W + 2 + 3 * SW;
    localparam int LAT  = 9 + ROOT_W + 1 + UW + 3 + UW + 1;
    localparam logic [UW-1:0]        ONE_U = UW'(1) << FRAC_BITS;
    localparam logic signed [SW:0]   ONE_S = (SW+1)'(1) << FRAC_BITS;
    localparam word_t                ONE_W = word_t'(1) << FRAC_BITS;

    // ---------------- configuration ----------------
    logic [1:0] amb_reg;
    logic [1:0] ref_reg;

    // write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amb_reg <= 2'd3;
            ref_reg <= 2'd2;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_AMBIENT:   amb_reg <= pwdata[1:0];
                REG_REFERENCE: ref_reg <= pwdata[1:0];
                default:       amb_reg <= amb_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_AMBIENT:   prdata = {30'd0, amb_reg};
            REG_REFERENCE: prdata = {30'd0, ref_reg};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // ---------------- stage 1: capture and classify ----------------
    side_t      side_in;
    logic [3:0] cells;

    always_comb
    begin
        side_in      = '0;
        side_in.amb  = amb_reg;
        side_in.a    = {in5, in4, in3, in2, in1, in0};
        cells        = 4'(amb_reg) * 4'(ref_reg);
        if (amb_reg <= ref_reg)
        begin
            side_in.mode = MODE_PASS;
            side_in.cnt  = (cells > 4'd6) ? 3'd6 : cells[2:0];
        end
        else if (ref_reg == 2'd0)
            side_in.mode = MODE_IDENT;
        else if (ref_reg == 2'd1 && amb_reg == 2'd2)
            side_in.mode = MODE_NORM2;
        else if (ref_reg == 2'd1)
            side_in.mode = MODE_HH3;
        else
            side_in.mode = MODE_CROSS3;
    end

    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    side_t side6_reg, side7_reg, side8_reg, side9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0;
            v7_reg <= 1'b0; v8_reg <= 1'b0; v9_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg;
            v8_reg <= v7_reg; v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side_in;
    end

    // ---------------- stage 2: cross-product partial products ----------------
    logic signed [5:0][WIDE_W-1:0] prod2_reg;

    always_ff @(posedge clk)
    begin
        side2_reg    <= side1_reg;
        prod2_reg[0] <= $signed(side1_reg.a[2]) * $signed(side1_reg.a[5]);
        prod2_reg[1] <= $signed(side1_reg.a[4]) * $signed(side1_reg.a[3]);
        prod2_reg[2] <= $signed(side1_reg.a[4]) * $signed(side1_reg.a[1]);
        prod2_reg[3] <= $signed(side1_reg.a[0]) * $signed(side1_reg.a[5]);
        prod2_reg[4] <= $signed(side1_reg.a[0]) * $signed(side1_reg.a[3]);
        prod2_reg[5] <= $signed(side1_reg.a[2]) * $signed(side1_reg.a[1]);
    end

    // ---------------- stage 3: magnitudes and signs ----------------
    logic [2:0][WIDE_W-1:0] mg3_next, mg3_reg;
    side_t                  side3_next;
    logic signed [WIDE_W:0] dif3;
    logic signed [WORD_W:0] ent3;

    always_comb
    begin
        side3_next = side2_reg;
        mg3_next   = '0;
        dif3       = '0;
        ent3       = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (side2_reg.mode == MODE_CROSS3)
            begin
                dif3 = (WIDE_W+1)'($signed(prod2_reg[2*i]))
                       - (WIDE_W+1)'($signed(prod2_reg[2*i+1]));
                side3_next.neg[i] = dif3[WIDE_W];
                mg3_next[i] = dif3[WIDE_W] ? WIDE_W'(-dif3) : WIDE_W'(dif3);
            end
            else
            begin
                ent3 = (WORD_W+1)'($signed(side2_reg.a[i]));
                side3_next.neg[i] = ent3[WORD_W];
                mg3_next[i] = ent3[WORD_W] ? WIDE_W'(-ent3) : WIDE_W'(ent3);
            end
        end
        // the planar normal only looks at two entries
        if (side2_reg.mode == MODE_NORM2)
            mg3_next[2] = '0;
    end

    always_ff @(posedge clk)
    begin
        side3_reg <= side3_next;
        mg3_reg   <= mg3_next;
    end

    // ---------------- stages 4..6: leading-one search ----------------
    logic [2:0][WIDE_W-1:0] mg4_reg, mg5_reg, mg6_reg;
    logic [WIDE_W-1:0]      orw4_reg;
    logic [7:0]             any5_next, any5_reg;
    logic [7:0][2:0]        pos5_next, pos5_reg;
    logic [5:0]             top6_next, top6_reg;
    logic                   zero6_reg;

    always_ff @(posedge clk)
    begin
        side4_reg <= side3_reg;
        mg4_reg   <= mg3_reg;
        orw4_reg  <= mg3_reg[0] | mg3_reg[1] | mg3_reg[2];
    end

    // top bit within each byte
    always_comb
    begin
        for (int g = 0; g < 8; g++)
        begin
            any5_next[g] = |orw4_reg[8*g +: 8];
            pos5_next[g] = '0;
            for (int b = 0; b < 8; b++)
                if (orw4_reg[8*g + b])
                    pos5_next[g] = 3'(b);
        end
    end

    always_ff @(posedge clk)
    begin
        side5_reg <= side4_reg;
        mg5_reg   <= mg4_reg;
        any5_reg  <= any5_next;
        pos5_reg  <= pos5_next;
    end

    // top byte holding a set bit
    always_comb
    begin
        top6_next = '0;
        for (int g = 0; g < 8; g++)
            if (any5_reg[g])
                top6_next = {3'(g), pos5_reg[g]};
    end

    always_ff @(posedge clk)
    begin
        side6_reg <= side5_reg;
        mg6_reg   <= mg5_reg;
        top6_reg  <= top6_next;
        zero6_reg <= ~|any5_reg;
    end

    // ---------------- stage 7: normalise to [2^30, 2^31) ----------------
    logic [2:0][30:0] m7_next, m7_reg;
    logic [5:0]       rsh7, lsh7;
    side_t            side7_next;

    always_comb
    begin
        rsh7 = top6_reg - 6'd30;
        lsh7 = 6'd30 - top6_reg;
        side7_next = side6_reg;
        side7_next.degen = zero6_reg && (side6_reg.mode == MODE_NORM2 ||
                                         side6_reg.mode == MODE_HH3 ||
                                         side6_reg.mode == MODE_CROSS3);
        for (int i = 0; i < 3; i++)
        begin
            if (top6_reg >= 6'd30)
                m7_next[i] = 31'(mg6_reg[i] >> rsh7);
            else
                m7_next[i] = 31'(mg6_reg[i] << lsh7);
        end
    end

    always_ff @(posedge clk)
    begin
        side7_reg <= side7_next;
        m7_reg    <= m7_next;
    end

    // ---------------- stages 8..9: sum of squares ----------------
    logic [2:0][30:0]    m8_reg, m9_reg;
    logic [2:0][61:0]    sq8_reg;
    logic [WIDE_W-1:0]   sum9_reg;

    always_ff @(posedge clk)
    begin
        side8_reg <= side7_reg;
        m8_reg    <= m7_reg;
        for (int i = 0; i < 3; i++)
            sq8_reg[i] <= 62'(m7_reg[i]) * 62'(m7_reg[i]);
        side9_reg <= side8_reg;
        m9_reg    <= m8_reg;
        sum9_reg  <= WIDE_W'(sq8_reg[0]) + WIDE_W'(sq8_reg[1]) + WIDE_W'(sq8_reg[2]);
    end

    // ---------------- square root, one root bit per stage ----------------
    logic [ROOT_W-1:0]                 sq_valid_reg;
    logic [ROOT_W-1:0][ROOT_W-1:0]     sq_root_reg;
    logic [ROOT_W-2:0][WIDE_W-1:0]     sq_rem_reg;
    logic [ROOT_W-1:0][2:0][30:0]      sq_m_reg;
    side_t [ROOT_W-1:0]                sq_side_reg;

    for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
        localparam int BIT = ROOT_W - 1 - s;
        logic              valid_in;
        logic [WIDE_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [2:0][30:0]  m_in;
        side_t             side_s;
        logic [WIDE_W+1:0] trial;
        logic              take;

        if (s == 0) begin : g_first
            assign valid_in = v9_reg;
            assign rem_in   = sum9_reg;
            assign root_in  = '0;
            assign m_in     = m9_reg;
            assign side_s   = side9_reg;
        end else begin : g_next
            assign valid_in = sq_valid_reg[s-1];
            assign rem_in   = sq_rem_reg[s-1];
            assign root_in  = sq_root_reg[s-1];
            assign m_in     = sq_m_reg[s-1];
            assign side_s   = sq_side_reg[s-1];
        end

        // try the next root bit against the running remainder
        assign trial = ((WIDE_W+2)'(root_in) << (BIT + 1)) + ((WIDE_W+2)'(1) << (2 * BIT));
        assign take  = (WIDE_W+2)'(rem_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[s] <= 1'b0;
            else
                sq_valid_reg[s] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            sq_root_reg[s] <= take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
            sq_m_reg[s]    <= m_in;
            sq_side_reg[s] <= side_s;
        end

        if (s < ROOT_W - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                sq_rem_reg[s] <= take ? WIDE_W'((WIDE_W+2)'(rem_in) - trial) : rem_in;
            end
        end
    end

    // ---------------- pre-divide: rounded numerators ----------------
    logic                   vp_reg;
    side_t                  sidep_reg;
    logic [2:0][WIDE_W-1:0] nump_reg;
    logic [ROOT_W-1:0]      nrmp_reg;
    logic [ROOT_W-1:0]      nrm;

    assign nrm = sq_root_reg[ROOT_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= 1'b0;
        else
            vp_reg <= sq_valid_reg[ROOT_W-1];
    end

    always_ff @(posedge clk)
    begin
        sidep_reg <= sq_side_reg[ROOT_W-1];
        nrmp_reg  <= nrm;
        for (int i = 0; i < 3; i++)
            nump_reg[i] <= (WIDE_W'(sq_m_reg[ROOT_W-1][i]) << FRAC_BITS)
                           + WIDE_W'(nrm >> 1);
    end

    // ---------------- first divider: unit components ----------------
    logic               d1_valid;
    logic [2:0][UW-1:0] d1_quo;
    logic [SIDE_W-1:0]  d1_side;
    side_t              d1_s;

    jfc_div_pipe #(
        .NUM_W  (WIDE_W),
        .DEN_W  (ROOT_W),
        .QUO_W  (UW),
        .SIDE_W (SIDE_W),
        .LANES  (3)
    ) u_div_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vp_reg),
        .num       (nump_reg),
        .den       (nrmp_reg),
        .side_in   (sidep_reg),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    assign d1_s = side_t'(d1_side);

    // ---------------- H1: apply signs ----------------
    logic                 vh1_reg, vh2_reg, vh3_reg;
    side_t                sideh1_reg, sideh2_reg, sideh3_reg;
    logic signed [SW-1:0] sx1_reg, sy1_reg, sz1_reg;
    logic signed [SW-1:0] sx2_reg, sy2_reg, sz2_reg;
    logic signed [SW-1:0] sx3_reg, sy3_reg, sz3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vh1_reg <= 1'b0;
            vh2_reg <= 1'b0;
            vh3_reg <= 1'b0;
        end
        else
        begin
            vh1_reg <= d1_valid;
            vh2_reg <= vh1_reg;
            vh3_reg <= vh2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sideh1_reg <= d1_s;
        sx1_reg <= d1_s.neg[0] ? -$signed({1'b0, d1_quo[0]}) : $signed({1'b0, d1_quo[0]});
        sy1_reg <= d1_s.neg[1] ? -$signed({1'b0, d1_quo[1]}) : $signed({1'b0, d1_quo[1]});
        sz1_reg <= d1_s.neg[2] ? -$signed({1'b0, d1_quo[2]}) : $signed({1'b0, d1_quo[2]});
    end

    // ---------------- H2: reflection products and divisor ----------------
    logic signed [PW-1:0] yy2_reg, yz2_reg, zz2_reg;
    logic [SW-1:0]        dv2_reg;
    logic                 xpos2_reg;
    logic                 xpos1;
    logic signed [SW:0]   dsum1;

    assign xpos1 = !sx1_reg[SW-1] && (sx1_reg != '0);
    assign dsum1 = xpos1 ? (ONE_S + (SW+1)'(sx1_reg)) : (ONE_S - (SW+1)'(sx1_reg));

    always_ff @(posedge clk)
    begin
        sideh2_reg <= sideh1_reg;
        sx2_reg    <= sx1_reg;
        sy2_reg    <= sy1_reg;
        sz2_reg    <= sz1_reg;
        yy2_reg    <= sy1_reg * sy1_reg;
        yz2_reg    <= sy1_reg * sz1_reg;
        zz2_reg    <= sz1_reg * sz1_reg;
        dv2_reg    <= dsum1[SW-1:0];
        xpos2_reg  <= xpos1;
    end

    // ---------------- H3: rounded numerators ----------------
    logic [2:0][NW2-1:0]  num3_reg;
    logic [SW-1:0]        dv3_reg;
    logic                 xpos3_reg, yzneg3_reg;
    logic [NW2-1:0]       yz_mag2;

    assign yz_mag2 = yz2_reg[PW-1] ? NW2'(-yz2_reg) : NW2'(yz2_reg);

    always_ff @(posedge clk)
    begin
        sideh3_reg  <= sideh2_reg;
        sx3_reg     <= sx2_reg;
        sy3_reg     <= sy2_reg;
        sz3_reg     <= sz2_reg;
        dv3_reg     <= dv2_reg;
        xpos3_reg   <= xpos2_reg;
        yzneg3_reg  <= yz2_reg[PW-1];
        num3_reg[0] <= NW2'(yy2_reg) + NW2'(dv2_reg >> 1);
        num3_reg[1] <= yz_mag2 + NW2'(dv2_reg >> 1);
        num3_reg[2] <= NW2'(zz2_reg) + NW2'(dv2_reg >> 1);
    end

    // ---------------- second divider: reflection terms ----------------
    logic                 d2_valid;
    logic [2:0][UW-1:0]   d2_quo;
    logic [SIDE2_W-1:0]   d2_side;
    side_t                f_side;
    logic                 f_xpos, f_yzneg;
    logic signed [SW-1:0] f_sx, f_sy, f_sz;

    jfc_div_pipe #(
        .NUM_W  (NW2),
        .DEN_W  (SW),
        .QUO_W  (UW),
        .SIDE_W (SIDE2_W),
        .LANES  (3)
    ) u_div_refl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vh3_reg),
        .num       (num3_reg),
        .den       (dv3_reg),
        .side_in   ({sideh3_reg, xpos3_reg, yzneg3_reg, sx3_reg, sy3_reg, sz3_reg}),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    assign {f_side, f_xpos, f_yzneg, f_sx, f_sy, f_sz} = d2_side;

    // ---------------- final: assemble the square matrix ----------------
    word_t [8:0] mm;
    word_t       wx, wy, wz, qyy, qyz, qzz;
    logic        done_reg;
    word_t [8:0] m_reg;
    logic        degen_reg;

    always_comb
    begin
        wx  = word_t'(f_sx);
        wy  = word_t'(f_sy);
        wz  = word_t'(f_sz);
        qyy = word_t'(d2_quo[0]);
        qyz = f_yzneg ? -word_t'(d2_quo[1]) : word_t'(d2_quo[1]);
        qzz = word_t'(d2_quo[2]);
        mm  = '0;
        unique case (f_side.mode)
            MODE_PASS:
            begin
                for (int k = 0; k < 6; k++)
                    if (3'(k) < f_side.cnt)
                        mm[k] = f_side.a[k];
            end
            MODE_IDENT:
            begin
                case (f_side.amb)
                    2'd1:    mm[0] = ONE_W;
                    2'd2:    begin mm[0] = ONE_W; mm[3] = ONE_W; end
                    default: begin mm[0] = ONE_W; mm[4] = ONE_W; mm[8] = ONE_W; end
                endcase
            end
            MODE_NORM2:
            begin
                mm[0] = f_side.a[0];
                mm[2] = f_side.a[1];
                if (!f_side.degen)
                begin
                    mm[1] = -wy;
                    mm[3] = wx;
                end
            end
            MODE_HH3:
            begin
                mm[0] = f_side.a[0];
                mm[3] = f_side.a[1];
                mm[6] = f_side.a[2];
                if (!f_side.degen)
                begin
                    if (f_xpos)
                    begin
                        mm[1] = -wy;
                        mm[2] = -wz;
                        mm[4] = ONE_W - qyy;
                        mm[5] = -qyz;
                        mm[7] = -qyz;
                        mm[8] = ONE_W - qzz;
                    end
                    else
                    begin
                        mm[1] = wz;
                        mm[2] = wy;
                        mm[4] = -qyz;
                        mm[5] = ONE_W - qyy;
                        mm[7] = ONE_W - qzz;
                        mm[8] = -qyz;
                    end
                end
            end
            MODE_CROSS3:
            begin
                mm[0] = f_side.a[0];
                mm[1] = f_side.a[1];
                mm[3] = f_side.a[2];
                mm[4] = f_side.a[3];
                mm[6] = f_side.a[4];
                mm[7] = f_side.a[5];
                if (!f_side.degen)
                begin
                    mm[2] = wx;
                    mm[5] = wy;
                    mm[8] = wz;
                end
            end
            default: mm = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= mm;
        degen_reg <= f_side.degen;
    end

    assign done       = done_reg;
    assign m0         = m_reg[0];
    assign m1         = m_reg[1];
    assign m2         = m_reg[2];
    assign m3         = m_reg[3];
    assign m4         = m_reg[4];
    assign m5         = m_reg[5];
    assign m6         = m_reg[6];
    assign m7         = m_reg[7];
    assign m8         = m_reg[8];
    assign degenerate = degen_reg;

    // ---------------- checks ----------------
`include "jacobian_frame_completion_top_assert.svh"

    `JFC_ASSERT_IMP(a_latency, start && !busy, ##LAT done)
    `JFC_ASSERT_NXT(a_norm_range, v6_reg && !zero6_reg, m7_reg[0][30] || m7_reg[1][30] || m7_reg[2][30])
    `JFC_ASSERT_IMP(a_unit_bound, d1_valid && !d1_s.degen && d1_s.mode != MODE_PASS && d1_s.mode != MODE_IDENT, (d1_quo[0] <= ONE_U) && (d1_quo[1] <= ONE_U) && (d1_quo[2] <= ONE_U))

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for jacobian_frame_completion_top.
// Depends on jfc_pkg and the block's RTL; predicts each completed frame and checks it.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import jfc_pkg::*;

    localparam int           FRAC     = 16;
    localparam longint       ONE_Q    = 64'sd1 << FRAC;
    localparam int           SETTLE   = 120;
    localparam int           LIMIT    = 400000;
    localparam logic [2:0]   ADDR_AMB = {REG_AMBIENT, 2'b00};
    localparam logic [2:0]   ADDR_REF = {REG_REFERENCE, 2'b00};

    typedef struct {
        word_t a [6];
    } request_t;

    typedef struct {
        word_t m [9];
        logic  degen;
    } frame_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    word_t       in0, in1, in2, in3, in4, in5;
    logic        done;
    word_t       m0, m1, m2, m3, m4, m5, m6, m7, m8;
    logic        degenerate;

    request_t    request_q [$];
    frame_t      frame_q [$];
    logic [1:0]  amb_cfg;
    logic [1:0]  ref_cfg;
    int          idle_pct;
    logic        taken;
    int          errors;
    int          cycles;

    jacobian_frame_completion_top #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .in0(in0), .in1(in1), .in2(in2), .in3(in3), .in4(in4), .in5(in5),
        .done(done),
        .m0(m0), .m1(m1), .m2(m2), .m3(m3), .m4(m4), .m5(m5), .m6(m6), .m7(m7),
        .m8(m8), .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] mag_of(longint v);
        return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint signed_of(logic [63:0] mg, logic neg);
        return neg ? -longint'(mg) : longint'(mg);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // normalise three magnitudes; returns 0 when all are zero
    function automatic logic unit_vec(input logic [2:0][63:0] mg,
                                      output logic [2:0][63:0] u);
        logic [2:0][63:0] m;
        logic [63:0]      mx;
        logic [63:0]      sum;
        logic [63:0]      nrm;
        m   = mg;
        mx  = 64'd0;
        sum = 64'd0;
        u   = '0;
        for (int i = 0; i < 3; i++)
            if (m[i] > mx)
                mx = m[i];
        if (mx == 0)
            return 1'b0;
        while (mx >= (64'd1 << 31))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            sum = sum + m[i] * m[i];
        nrm = floor_sqrt(sum);
        for (int i = 0; i < 3; i++)
            u[i] = ((m[i] << FRAC) + nrm / 2) / nrm;
        return 1'b1;
    endfunction

    // round p / d half away from zero, d positive
    function automatic longint round_div(longint p, longint d);
        logic [63:0] q;
        q = (mag_of(p) + 64'(d) / 2) / 64'(d);
        return signed_of(q, p < 0);
    endfunction

    // exact a*b - c*d as magnitude and sign
    function automatic logic [63:0] cross_part(longint a, longint b, longint c, longint d,
                                               output logic neg);
        longint p;
        longint q;
        p = a * b;
        q = c * d;
        neg = (p < q);
        return neg ? 64'(q) - 64'(p) : 64'(p) - 64'(q);
    endfunction

    function automatic frame_t complete_frame(request_t rq, logic [1:0] de, logic [1:0] dm);
        longint           j [9];
        longint           a [6];
        logic [2:0][63:0] mg;
        logic [2:0][63:0] u;
        logic [2:0]       ng;
        longint           x, y, z, d;
        int               n;
        frame_t           f;
        f.degen = 1'b0;
        for (int i = 0; i < 9; i++)
            j[i] = 0;
        for (int i = 0; i < 6; i++)
            a[i] = longint'(rq.a[i]);
        mg = '0;
        if (de <= dm)
        begin
            n = int'(de) * int'(dm);
            if (n > 6)
                n = 6;
            for (int i = 0; i < n; i++)
                j[i] = a[i];
        end
        else if (dm == 0)
        begin
            for (int i = 0; i < int'(de); i++)
                j[i * int'(de) + i] = ONE_Q;
        end
        else if (dm == 1 && de == 2)
        begin
            j[0] = a[0];
            j[2] = a[1];
            mg[0] = mag_of(a[0]);
            mg[1] = mag_of(a[1]);
            if (unit_vec(mg, u))
            begin
                j[1] = signed_of(u[1], !(a[1] < 0));
                j[3] = signed_of(u[0], a[0] < 0);
            end
            else
                f.degen = 1'b1;
        end
        else if (dm == 1)
        begin
            j[0] = a[0];
            j[3] = a[1];
            j[6] = a[2];
            for (int i = 0; i < 3; i++)
                mg[i] = mag_of(a[i]);
            if (unit_vec(mg, u))
            begin
                x = signed_of(u[0], a[0] < 0);
                y = signed_of(u[1], a[1] < 0);
                z = signed_of(u[2], a[2] < 0);
                // reflect away from the larger of e1 and -e1
                if (x > 0)
                begin
                    d = ONE_Q + x;
                    j[1] = -y;
                    j[2] = -z;
                    j[4] = ONE_Q - round_div(y * y, d);
                    j[5] = -round_div(y * z, d);
                    j[7] = j[5];
                    j[8] = ONE_Q - round_div(z * z, d);
                end
                else
                begin
                    d = ONE_Q - x;
                    j[1] = z;
                    j[2] = y;
                    j[4] = -round_div(y * z, d);
                    j[5] = ONE_Q - round_div(y * y, d);
                    j[7] = ONE_Q - round_div(z * z, d);
                    j[8] = j[4];
                end
            end
            else
                f.degen = 1'b1;
        end
        else
        begin
            j[0] = a[0]; j[1] = a[1]; j[3] = a[2];
            j[4] = a[3]; j[6] = a[4]; j[7] = a[5];
            mg[0] = cross_part(j[3], j[7], j[6], j[4], ng[0]);
            mg[1] = cross_part(j[6], j[1], j[0], j[7], ng[1]);
            mg[2] = cross_part(j[0], j[4], j[3], j[1], ng[2]);
            if (unit_vec(mg, u))
            begin
                j[2] = signed_of(u[0], ng[0]);
                j[5] = signed_of(u[1], ng[1]);
                j[8] = signed_of(u[2], ng[2]);
            end
            else
                f.degen = 1'b1;
        end
        for (int i = 0; i < 9; i++)
            f.m[i] = word_t'(j[i][31:0]);
        return f;
    endfunction

    function automatic word_t rand_entry();
        int sel;
        sel = $urandom_range(15);
        case (sel)
            0, 1: return 32'sd0;
            2:    return 32'h7fffffff;
            3:    return 32'h80000000;
            4:    return word_t'($urandom_range(3)) - 32'sd1;
            5, 6: return word_t'($urandom_range(2 * ONE_Q)) - word_t'(ONE_Q);
            7:    return word_t'($urandom_range(4095)) - 32'sd2048;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic push_fill(word_t v);
        request_t rq;
        for (int i = 0; i < 6; i++)
            rq.a[i] = v;
        request_q.push_back(rq);
    endtask

    task automatic push_random();
        request_t rq;
        for (int i = 0; i < 6; i++)
            rq.a[i] = rand_entry();
        request_q.push_back(rq);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for every request and frame to drain, then let the pipe settle
    task automatic drain();
        while (request_q.size() != 0 || start || frame_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // request driver: advance on acceptance, idle at random
    always @(negedge clk)
    begin
        if (rst_n && (!start || taken))
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                request_t rq;
                rq = request_q.pop_front();
                in0 <= rq.a[0]; in1 <= rq.a[1]; in2 <= rq.a[2];
                in3 <= rq.a[3]; in4 <= rq.a[4]; in5 <= rq.a[5];
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: predict on acceptance, check each strobed frame
    always @(posedge clk)
    begin
        request_t rq;
        frame_t   got;
        frame_t   want;
        logic     bad;
        taken <= start && !busy && rst_n;
        if (rst_n && start && !busy)
        begin
            rq.a[0] = in0; rq.a[1] = in1; rq.a[2] = in2;
            rq.a[3] = in3; rq.a[4] = in4; rq.a[5] = in5;
            frame_q.push_back(complete_frame(rq, amb_cfg, ref_cfg));
        end
        if (rst_n && done)
        begin
            got.m[0] = m0; got.m[1] = m1; got.m[2] = m2;
            got.m[3] = m3; got.m[4] = m4; got.m[5] = m5;
            got.m[6] = m6; got.m[7] = m7; got.m[8] = m8;
            got.degen = degenerate;
            if (frame_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("frame with no request outstanding");
            end
            else
            begin
                want = frame_q.pop_front();
                bad = (got.degen !== want.degen);
                for (int i = 0; i < 9; i++)
                    if (got.m[i] !== want.m[i])
                        bad = 1'b1;
                if (bad)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("frame mismatch (amb %0d ref %0d)", amb_cfg, ref_cfg);
                        for (int i = 0; i < 9; i++)
                            $display("  m%0d exp %h got %h", i, want.m[i], got.m[i]);
                        $display("  degenerate exp %b got %b", want.degen, got.degen);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] amb_set [12];
        logic [1:0] ref_set [12];
        amb_set = '{2'd3, 2'd3, 2'd2, 2'd3, 2'd1, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3};
        ref_set = '{2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd2};
        errors   = 0;
        cycles   = 0;
        idle_pct = 0;
        taken    = 1'b0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        start    = 1'b0;
        in0 = '0; in1 = '0; in2 = '0; in3 = '0; in4 = '0; in5 = '0;
        amb_cfg  = 2'd3;
        ref_cfg  = 2'd2;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 12; p++)
        begin
            // program the shape for this phase while the pipe is empty
            if (p != 0)
            begin
                reg_write(ADDR_AMB, {2'($urandom_range(3)), 28'd0, amb_set[p]});
                reg_write(ADDR_REF, {2'($urandom_range(3)), 28'd0, ref_set[p]});
                amb_cfg = amb_set[p];
                ref_cfg = ref_set[p];
            end
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 71;
                default: idle_pct = 10;
            endcase
            // zero norm, extremes, unit and small values
            push_fill(32'sd0);
            push_fill(32'h7fffffff);
            push_fill(32'h80000000);
            push_fill(word_t'(ONE_Q));
            push_fill(-word_t'(ONE_Q));
            push_fill(32'sd1);
            push_fill(-32'sd1);
            for (int k = 0; k < 120; k++)
                push_random();
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
